>>> hdl/pmq_pkg.sv
// ----------------------------------------------------------------------------
// pmq_pkg - shared types for the priority mail queue
// Item kinds, result codes, slot and FSM states and the chain control word.
// ----------------------------------------------------------------------------
package pmq_pkg;

    typedef enum logic [1:0] {
        KIND_SEND    = 2'd0,
        KIND_RECEIVE = 2'd1,
        KIND_CANCEL  = 2'd2,
        KIND_DONE    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        RES_OK          = 3'd0,
        RES_CANCEL_WAIT = 3'd1,
        RES_CANCEL_EXEC = 3'd2,
        RES_FULL        = 3'd3,
        RES_EMPTY       = 3'd4
    } res_t;

    typedef enum logic [1:0] {
        SLOT_FREE  = 2'd0,
        SLOT_READY = 2'd1,
        SLOT_EXEC  = 2'd2,
        SLOT_STOP  = 2'd3
    } slot_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_POP  = 1'b1
    } state_t;

    // control broadcast to every cell of the order chain
    typedef struct packed {
        logic       ins;
        logic       pop;
        logic [7:0] prio;
    } chain_ctl_t;

endpackage

>>> hdl/pmq_cell.sv
// ----------------------------------------------------------------------------
// pmq_cell - one position of the sorted order chain
// Holds one queued slot handle and its priority; shifts on insert and pop.
// ----------------------------------------------------------------------------
module pmq_cell #(
    parameter int IW = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pmq_pkg::chain_ctl_t  ctl,
    input  logic [IW-1:0]        new_hnd,
    input  logic                 left_after,
    input  logic                 left_valid,
    input  logic [IW-1:0]        left_hnd,
    input  logic [7:0]           left_prio,
    input  logic                 right_valid,
    input  logic [IW-1:0]        right_hnd,
    input  logic [7:0]           right_prio,
    output logic                 after,
    output logic                 valid,
    output logic [IW-1:0]        hnd,
    output logic [7:0]           prio
);
    import pmq_pkg::*;

    logic          valid_reg, valid_next;
    logic [IW-1:0] hnd_reg, hnd_next;
    logic [7:0]    prio_reg, prio_next;

    // new item goes behind every entry of equal or lower number
    assign after = !valid_reg || (prio_reg > ctl.prio);

    always_comb
    begin
        valid_next = valid_reg;
        hnd_next   = hnd_reg;
        prio_next  = prio_reg;
        if (ctl.pop)
        begin
            valid_next = right_valid;
            hnd_next   = right_hnd;
            prio_next  = right_prio;
        end
        else if (ctl.ins && after)
        begin
            if (left_after)
            begin
                valid_next = left_valid;
                hnd_next   = left_hnd;
                prio_next  = left_prio;
            end
            else
            begin
                valid_next = 1'b1;
                hnd_next   = new_hnd;
                prio_next  = ctl.prio;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        hnd_reg  <= hnd_next;
        prio_reg <= prio_next;
    end

    assign valid = valid_reg;
    assign hnd   = hnd_reg;
    assign prio  = prio_reg;

endmodule

>>> hdl/priority_mail_queue.sv
// ----------------------------------------------------------------------------
// priority_mail_queue - bounded mailbox queue sorted by priority
// Slot table plus a chain of cells that keeps queued slots in service order.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with an item while busy is low; the item is taken at that
//   edge. kind selects send, receive, cancel or done.
//   Each item gives one result, shown for exactly one cycle with valid high.
//   The receiver cannot stall, so results are never held back.
//   Send, cancel and done: result in the cycle after the item, one item per
//   cycle. Receive: busy rises after the item and one chain entry is popped
//   per cycle; stopped heads are freed on the way until a ready head or an
//   empty chain is met, and busy drops in the cycle the result shows. A receive
//   on an empty chain answers with status empty.
//   Insertion is done by all chain cells together: each compares its
//   priority with the new one and shifts right behind the insert point.
//   kernel_priority reads back at address 0 of the APB port, and a write to
//   either address sets it; write it only while the block is idle. pready is
//   always high. Reset frees every slot, empties the chain and clears kernel_priority.
// ----------------------------------------------------------------------------
module priority_mail_queue #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  priority_req,
    input  logic [7:0]  sender_id,
    input  logic        from_interrupt,
    input  logic        wants_reply,
    input  logic [3:0]  handle,
    input  logic [31:0] result_value,
    output logic        valid,
    output logic [2:0]  status,
    output logic [3:0]  out_handle,
    output logic [7:0]  out_sender,
    output logic        sender_valid,
    output logic        reply_valid,
    output logic [31:0] reply_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pmq_pkg::*;

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // slot table
    slot_t      slot_st_reg   [DEPTH];
    logic       slot_wait_reg [DEPTH];
    logic       slot_chn_reg  [DEPTH];
    logic [8:0] slot_snd_reg  [DEPTH];

    logic [7:0] kprio_reg;
    state_t     state_reg, state_next;

    // result registers
    logic        valid_reg, valid_next;
    res_t        status_reg, status_next;
    logic [3:0]  ohnd_reg, ohnd_next;
    logic [7:0]  osnd_reg, osnd_next;
    logic        sval_reg, sval_next;
    logic        rval_reg, rval_next;
    logic [31:0] rword_reg, rword_next;

    // chain wiring
    logic          c_after [DEPTH];
    logic          c_valid [DEPTH];
    logic [IW-1:0] c_hnd   [DEPTH];
    logic [7:0]    c_prio  [DEPTH];
    chain_ctl_t    ctl;
    logic [IW-1:0] new_hnd;

    // table write controls
    logic          st_we, wt_we, ch_we, sd_we;
    logic [IW-1:0] st_idx, ch_idx;
    slot_t         st_val;
    logic          wt_val, ch_val;
    logic [7:0]    sd_prio;
    logic [8:0]    sd_snd;

    // lowest numbered free slot
    logic          free_found;
    logic [IW-1:0] free_idx;
    logic [31:0]   free_ext;

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = DEPTH - 1; i >= 0; i--)
        begin
            if (slot_st_reg[i] == SLOT_FREE)
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign free_ext = 32'(free_idx);

    logic [31:0]   hext;
    logic          h_ok;
    logic [IW-1:0] hsel;
    logic [31:0]   head_ext;
    logic [IW-1:0] head;

    assign hext     = 32'(handle);
    assign h_ok     = hext < DEPTH;
    assign hsel     = hext[IW-1:0];
    assign head     = c_hnd[0];
    assign head_ext = 32'(head);

    always_comb
    begin
        state_next  = state_reg;
        valid_next  = 1'b0;
        status_next = RES_OK;
        ohnd_next   = '0;
        osnd_next   = '0;
        sval_next   = 1'b0;
        rval_next   = 1'b0;
        rword_next  = '0;
        ctl         = '0;
        new_hnd     = free_idx;
        st_we = 1'b0; st_idx = hsel; st_val = SLOT_FREE;
        wt_we = 1'b0; wt_val = 1'b0;
        ch_we = 1'b0; ch_idx = free_idx; ch_val = 1'b0;
        sd_we = 1'b0;
        sd_prio = from_interrupt ? kprio_reg : priority_req;
        sd_snd  = from_interrupt ? 9'd0 : {1'b1, sender_id};
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (kind_t'(kind))
                        KIND_SEND:
                        begin
                            valid_next = 1'b1;
                            if (!free_found)
                                status_next = RES_FULL;
                            else
                            begin
                                ohnd_next = free_ext[3:0];
                                st_we  = 1'b1; st_idx = free_idx; st_val = SLOT_READY;
                                wt_we  = 1'b1; wt_val = !from_interrupt && wants_reply;
                                ch_we  = 1'b1; ch_val = 1'b1;
                                sd_we  = 1'b1;
                                ctl.ins  = 1'b1;
                                ctl.prio = sd_prio;
                            end
                        end
                        KIND_RECEIVE:
                            state_next = ST_POP;
                        KIND_CANCEL:
                        begin
                            valid_next = 1'b1;
                            if (h_ok && slot_st_reg[hsel] == SLOT_READY)
                                status_next = RES_CANCEL_WAIT;
                            else if (h_ok && slot_st_reg[hsel] == SLOT_EXEC)
                                status_next = RES_CANCEL_EXEC;
                            else
                                status_next = RES_EMPTY;
                            if (status_next != RES_EMPTY)
                            begin
                                st_we = 1'b1; st_val = SLOT_STOP;
                                wt_we = 1'b1; wt_val = 1'b0;
                            end
                        end
                        default:
                        begin
                            valid_next = 1'b1;
                            if (h_ok && (slot_st_reg[hsel] == SLOT_EXEC ||
                                (slot_st_reg[hsel] == SLOT_STOP && !slot_chn_reg[hsel])))
                            begin
                                st_we = 1'b1; st_val = SLOT_FREE;
                                wt_we = 1'b1; wt_val = 1'b0;
                                if (slot_wait_reg[hsel])
                                begin
                                    osnd_next  = slot_snd_reg[hsel][7:0];
                                    sval_next  = slot_snd_reg[hsel][8];
                                    rval_next  = 1'b1;
                                    rword_next = result_value;
                                end
                            end
                            else
                                status_next = RES_EMPTY;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                if (!c_valid[0])
                begin
                    valid_next  = 1'b1;
                    status_next = RES_EMPTY;
                    state_next  = ST_IDLE;
                end
                else
                begin
                    ctl.pop = 1'b1;
                    ch_we = 1'b1; ch_idx = head; ch_val = 1'b0;
                    st_we = 1'b1; st_idx = head;
                    if (slot_st_reg[head] == SLOT_READY)
                    begin
                        st_val     = SLOT_EXEC;
                        valid_next = 1'b1;
                        ohnd_next  = head_ext[3:0];
                        osnd_next  = slot_snd_reg[head][7:0];
                        sval_next  = slot_snd_reg[head][8];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // drop a stopped head and keep popping
                        st_val = SLOT_FREE;
                        wt_we  = 1'b1; wt_val = 1'b0;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++)
        begin : g_cell
            logic          l_after, l_valid, r_valid;
            logic [IW-1:0] l_hnd, r_hnd;
            logic [7:0]    l_prio, r_prio;
            if (g == 0)
            begin : g_first
                assign l_after = 1'b0;
                assign l_valid = 1'b0;
                assign l_hnd   = '0;
                assign l_prio  = '0;
            end
            else
            begin : g_mid
                assign l_after = c_after[g-1];
                assign l_valid = c_valid[g-1];
                assign l_hnd   = c_hnd[g-1];
                assign l_prio  = c_prio[g-1];
            end
            if (g == DEPTH - 1)
            begin : g_last
                assign r_valid = 1'b0;
                assign r_hnd   = '0;
                assign r_prio  = '0;
            end
            else
            begin : g_inner
                assign r_valid = c_valid[g+1];
                assign r_hnd   = c_hnd[g+1];
                assign r_prio  = c_prio[g+1];
            end
            pmq_cell #(.IW(IW)) u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl),
                .new_hnd    (new_hnd),
                .left_after (l_after),
                .left_valid (l_valid),
                .left_hnd   (l_hnd),
                .left_prio  (l_prio),
                .right_valid(r_valid),
                .right_hnd  (r_hnd),
                .right_prio (r_prio),
                .after      (c_after[g]),
                .valid      (c_valid[g]),
                .hnd        (c_hnd[g]),
                .prio       (c_prio[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                slot_st_reg[i]   <= SLOT_FREE;
                slot_wait_reg[i] <= 1'b0;
                slot_chn_reg[i]  <= 1'b0;
            end
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            kprio_reg <= '0;
        end
        else
        begin
            if (st_we)
                slot_st_reg[st_idx] <= st_val;
            if (wt_we)
                slot_wait_reg[st_idx] <= wt_val;
            if (ch_we)
                slot_chn_reg[ch_idx] <= ch_val;
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (psel && penable && pwrite && pready)
                kprio_reg <= pwdata[7:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (sd_we)
            slot_snd_reg[free_idx] <= sd_snd;
        status_reg <= status_next;
        ohnd_reg   <= ohnd_next;
        osnd_reg   <= osnd_next;
        sval_reg   <= sval_next;
        rval_reg   <= rval_next;
        rword_reg  <= rword_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign valid        = valid_reg;
    assign status       = status_reg;
    assign out_handle   = ohnd_reg;
    assign out_sender   = osnd_reg;
    assign sender_valid = sval_reg;
    assign reply_valid  = rval_reg;
    assign reply_value  = rword_reg;
    assign prdata       = (paddr == 1'b0) ? {24'd0, kprio_reg} : 32'd0;
    assign pready       = 1'b1;

endmodule

>>> hdl/pmq_checker.sv
// ----------------------------------------------------------------------------
// pmq_port_checks - port-level checks for the priority mail queue
// Watches item acceptance and result strobes on the top level ports.
// ----------------------------------------------------------------------------
module pmq_port_checks (
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [1:0] kind,
    input logic       valid,
    input logic [2:0] status,
    input logic       sender_valid,
    input logic       reply_valid
);
    import pmq_pkg::*;

    a_quick_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind != KIND_RECEIVE) |=> (valid && !busy))
        else $error("non-receive item gave no result next cycle");

    a_receive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && kind == KIND_RECEIVE) |=> (busy && !valid))
        else $error("receive did not hold busy");

    a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> !busy)
        else $error("result shown while busy");

    a_reply_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (reply_valid || sender_valid)) |-> (status == RES_OK))
        else $error("sender or reply with bad status");

endmodule

bind priority_mail_queue pmq_port_checks u_pmq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .kind        (kind),
    .valid       (valid),
    .status      (status),
    .sender_valid(sender_valid),
    .reply_valid (reply_valid)
);
